### src/frs_pkg.sv
// frs_pkg: shared types, codes and constants for the serial frame receiver.
// Used by frs_csr, frs_core and serial_frame_receiver; depends on nothing.
package frs_pkg;

   // frame geometry
   localparam int DATA_BITS_DEF = 8;
   localparam int BYTE_BITS     = 8;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BIT_TICKS = 1'b0;
   localparam logic [15:0] BIT_TICKS_RESET = 16'd1000;

   // stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // receive phases
   localparam logic [1:0] PHASE_IDLE   = 2'd0;
   localparam logic [1:0] PHASE_DATA   = 2'd1;
   localparam logic [1:0] PHASE_PARITY = 2'd2;
   localparam logic [1:0] PHASE_STOP   = 2'd3;

   // frame status codes
   localparam logic [1:0] STATUS_GOOD       = 2'd0;
   localparam logic [1:0] STATUS_PARITY_ERR = 2'd1;
   localparam logic [1:0] STATUS_STOP_ERR   = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic [1:0] frame_status;
   } frs_result_type;

endpackage

### src/frs_csr.sv
// frs_csr: register port holding the bit period setting.
// Depends on frs_pkg for the register map and reset value.
module frs_csr
   import frs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [15:0]           bit_ticks
);

   logic [15:0] bit_ticks_ff;
   logic [15:0] bit_ticks_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[2] == REG_BIT_TICKS);

   always_comb begin
      bit_ticks_in = bit_ticks_ff;
      if (wr_en) begin
         bit_ticks_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ticks_ff <= BIT_TICKS_RESET;
      end else begin
         bit_ticks_ff <= bit_ticks_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_BIT_TICKS) begin
         csr_prdata = {16'd0, bit_ticks_ff};
      end
   end

   assign bit_ticks = bit_ticks_ff;

endmodule

### src/frs_core.sv
// frs_core: frame state machine, bit timing counter and data assembly.
// Depends on frs_pkg; consumes one registered line sample per step.
module frs_core
   import frs_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_valid,
   input  logic           step_level,
   input  logic [15:0]    bit_ticks,
   output frs_result_type result,
   output logic [1:0]     phase
);

   localparam int IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

   logic             prev_ff,      prev_in;
   logic [1:0]       phase_ff,     phase_in;
   logic [15:0]      tick_ff,      tick_in;
   logic [IDX_W-1:0] idx_ff,       idx_in;
   logic [7:0]       shift_ff,     shift_in;
   logic             parity_ff,    parity_in;
   logic             centering_ff, centering_in;

   logic        rx_bit;
   logic [15:0] half_ticks;
   logic [15:0] tick_inc;

   assign rx_bit     = ~step_level;
   assign half_ticks = bit_ticks >> 1;
   assign tick_inc   = (tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;

   always_comb begin
      prev_in      = prev_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      parity_in    = parity_ff;
      centering_in = centering_ff;
      result       = '0;
      result.data_byte = shift_ff;

      if (step_valid) begin
         prev_in = step_level;
         if (phase_ff == PHASE_IDLE) begin
            // start edge: line goes from high to low
            if (prev_ff && !step_level) begin
               phase_in     = PHASE_DATA;
               tick_in      = '0;
               idx_in       = '0;
               shift_in     = '0;
               parity_in    = 1'b0;
               centering_in = (half_ticks != 16'd0);
            end
         end else begin
            tick_in = tick_inc;
            if (centering_ff) begin
               if (tick_inc >= half_ticks) begin
                  centering_in = 1'b0;
                  tick_in      = '0;
               end
            end else if (tick_inc >= bit_ticks) begin
               tick_in = '0;
               unique case (phase_ff)
                  PHASE_DATA: begin
                     if (32'(idx_ff) < BYTE_BITS) begin
                        shift_in = shift_ff | (8'(rx_bit) << idx_ff);
                     end
                     parity_in = parity_ff ^ rx_bit;
                     if (32'(idx_ff) + 32'd1 >= 32'(DATA_BITS)) begin
                        idx_in   = '0;
                        phase_in = PHASE_PARITY;
                     end else begin
                        idx_in = idx_ff + 1'b1;
                     end
                  end
                  PHASE_PARITY: begin
                     if (rx_bit != parity_ff) begin
                        result.valid        = 1'b1;
                        result.frame_status = STATUS_PARITY_ERR;
                        phase_in            = PHASE_IDLE;
                     end else begin
                        phase_in = PHASE_STOP;
                     end
                  end
                  PHASE_STOP: begin
                     result.valid        = 1'b1;
                     result.frame_status = step_level ? STATUS_STOP_ERR : STATUS_GOOD;
                     phase_in            = PHASE_IDLE;
                  end
                  default: begin
                     phase_in = PHASE_IDLE;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 1'b1;
         phase_ff     <= PHASE_IDLE;
         tick_ff      <= '0;
         idx_ff       <= '0;
         shift_ff     <= '0;
         parity_ff    <= 1'b0;
         centering_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         idx_ff       <= idx_in;
         shift_ff     <= shift_in;
         parity_ff    <= parity_in;
         centering_ff <= centering_in;
      end
   end

   assign phase = phase_ff;

endmodule

### src/serial_frame_receiver.sv
// Serial frame receiver: takes one sample of an active-low receive line per input beat
// and returns one result beat per frame (data byte plus status). Throughput is one
// sample per clock while the input side is not stalled; a sample goes through an input
// register, the frame logic and the result register before its result beat is presented.
// The input side stalls only while a result beat is held and the output is not ready.
// bit_ticks sets the number of samples per bit period and is written over the csr port.
module serial_frame_receiver
   import frs_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] rx_level, [7:1] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [9:8] frame_status, [15:10] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic        in_valid_ff, in_valid_in;
   logic        in_level_ff, in_level_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic           advance;
   logic           step;
   logic [15:0]    bit_ticks;
   logic [1:0]     phase;
   frs_result_type result;

   frs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bit_ticks   (bit_ticks)
   );

   frs_core #(
      .DATA_BITS (DATA_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .step_level (in_level_ff),
      .bit_ticks  (bit_ticks),
      .result     (result),
      .phase      (phase)
   );

   // the result slot is free, or is emptied this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_level_in   = in_level_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_level_in = req_tdata[0];
      end
      if (advance) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_byte_in   = result.data_byte;
            rsp_status_in = result.frame_status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_level_ff   <= in_level_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_byte_ff};

   // no result can come out of the idle phase
   assert property (@(posedge clock) disable iff (reset)
      (phase == PHASE_IDLE) |-> !result.valid)
      else $error("result raised while receiver idle");

   // every result closes the frame
   assert property (@(posedge clock) disable iff (reset)
      result.valid |=> (phase == PHASE_IDLE))
      else $error("receiver did not return to idle after a result");

   // a result is only produced when the output slot can take it
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> advance)
      else $error("result produced while output stalled");

   // a valid result never carries an unused status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STATUS_GOOD || rsp_status_ff == STATUS_PARITY_ERR
                        || rsp_status_ff == STATUS_STOP_ERR))
      else $error("invalid frame status on result beat");

endmodule

### test/frs_frame_checker.sv
// frs_frame_checker: watches the sample, result and csr channels of the serial frame
// receiver, keeps its own model of the frame logic and compares every result beat.
// Depends on frs_pkg for widths, phase and status codes.
module frs_frame_checker
   import frs_pkg::*;
#(
   parameter int DATA_BITS = DATA_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] rx_level, [7:1] zero
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] data_byte, [9:8] frame_status, [15:10] zero
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    mismatch_count,
   output int                    frames_pending,
   output int                    frames_checked
);

   localparam int MAX_REPORTS = 30;
   localparam logic [CSR_ADDR_W-1:0] BIT_TICKS_ADDR = CSR_ADDR_W'(4 * int'(REG_BIT_TICKS));

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] frame_status;
   } frame_result_type;

   frame_result_type expected_frames[$];

   logic [15:0] bit_ticks_now;
   logic        line_prev;
   logic [1:0]  rx_phase;
   logic [15:0] tick_count;
   logic [3:0]  bit_pos;
   logic [7:0]  byte_acc;
   logic        parity_acc;
   logic        centring;

   function automatic void report(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
   endfunction

   function automatic void push_frame(input logic [1:0] status);
      frame_result_type res;
      res.data_byte    = byte_acc;
      res.frame_status = status;
      expected_frames.push_back(res);
      rx_phase = PHASE_IDLE;
   endfunction

   // one accepted line sample through the frame logic
   function automatic void track_line_sample(input logic level);
      logic data_val;
      data_val = ~level;
      if (rx_phase == PHASE_IDLE) begin
         if (line_prev && !level) begin
            rx_phase   = PHASE_DATA;
            tick_count = '0;
            bit_pos    = '0;
            byte_acc   = '0;
            parity_acc = 1'b0;
            centring   = (bit_ticks_now[15:1] != 0);
         end
         line_prev = level;
      end else begin
         line_prev = level;
         if (tick_count != 16'hFFFF)
            tick_count++;
         if (centring) begin
            // half-bit wait after the start edge
            if (tick_count >= {1'b0, bit_ticks_now[15:1]}) begin
               centring   = 1'b0;
               tick_count = '0;
            end
         end else if (tick_count >= bit_ticks_now) begin
            tick_count = '0;
            case (rx_phase)
               PHASE_DATA: begin
                  if (bit_pos < BYTE_BITS)
                     byte_acc[bit_pos[2:0]] = data_val;
                  parity_acc ^= data_val;
                  if (int'(bit_pos) + 1 >= DATA_BITS) begin
                     bit_pos  = '0;
                     rx_phase = PHASE_PARITY;
                  end else begin
                     bit_pos = bit_pos + 4'd1;
                  end
               end
               PHASE_PARITY: begin
                  if (data_val != parity_acc)
                     push_frame(STATUS_PARITY_ERR);
                  else
                     rx_phase = PHASE_STOP;
               end
               default: begin
                  push_frame(level ? STATUS_STOP_ERR : STATUS_GOOD);
               end
            endcase
         end
      end
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         bit_ticks_now = BIT_TICKS_RESET;
         line_prev     = 1'b1;
         rx_phase      = PHASE_IDLE;
         tick_count    = '0;
         bit_pos       = '0;
         byte_acc      = '0;
         parity_acc    = 1'b0;
         centring      = 1'b0;
         expected_frames.delete();
         frames_pending <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == BIT_TICKS_ADDR)
                  bit_ticks_now = csr_pwdata[15:0];
            end else if (csr_paddr == BIT_TICKS_ADDR &&
                         csr_prdata !== CSR_DATA_W'(bit_ticks_now)) begin
               report("bit_ticks readback", CSR_DATA_W'(bit_ticks_now), csr_prdata);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_frames.size() == 0) begin
               report("unexpected result beat", '0, 32'(rsp_tdata));
            end else begin
               want = expected_frames.pop_front();
               frames_checked++;
               if (rsp_tdata[7:0] !== want.data_byte)
                  report("data_byte", 32'(want.data_byte), 32'(rsp_tdata[7:0]));
               if (rsp_tdata[9:8] !== want.frame_status)
                  report("frame_status", 32'(want.frame_status), 32'(rsp_tdata[9:8]));
               if (rsp_tdata[RSP_DATA_W-1:10] !== '0)
                  report("tdata padding", '0, 32'(rsp_tdata[RSP_DATA_W-1:10]));
            end
         end
         if (req_tvalid && req_tready)
            track_line_sample(req_tdata[0]);
         frames_pending <= expected_frames.size();
      end
   end

endmodule

### test/tb_serial_frame_receiver.sv
// tb_serial_frame_receiver: drives line samples and bit period writes into the serial
// frame receiver and gives the verdict; prediction and comparison live in frs_frame_checker.
// Depends on frs_pkg, serial_frame_receiver and frs_frame_checker.
module tb_serial_frame_receiver;
   import frs_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLD_CYCLES    = 600;
   localparam int SAMPLE_TARGET  = 180;
   localparam int FRAME_TARGET   = 4;
   localparam int DRAIN_CYCLES   = 4;
   localparam logic [CSR_ADDR_W-1:0] BIT_TICKS_ADDR = CSR_ADDR_W'(4 * int'(REG_BIT_TICKS));

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [0] rx_level, [7:1] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [7:0] data_byte, [9:8] frame_status, [15:10] zero
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int   mismatch_count;
   int   frames_pending;
   int   frames_checked;
   int   idle_pct;
   int   stall_pct;
   int   cur_bit_ticks;
   int   samples_sent;
   int   frames_sent;
   int   settings_used;
   int   cycle_count;
   int   hold_left;
   logic hold_kick;

   always #10 clock = ~clock;

   serial_frame_receiver u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   frs_frame_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .frames_pending (frames_pending),
      .frames_checked (frames_checked)
   );

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_kick) begin
         hold_kick = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_sample(input logic level);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(level);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      samples_sent++;
   endtask

   task automatic send_cell(input logic level);
      repeat (cur_bit_ticks) send_sample(level);
   endtask

   task automatic idle_line(input int count);
      repeat (count) send_sample(1'b1);
   endtask

   // start cell, eight data cells, even parity cell, stop cell, then a high gap
   task automatic send_frame(input logic [7:0] data, input logic bad_parity,
                             input logic bad_stop, input int gap);
      logic par;
      par = (^data) ^ bad_parity;
      send_cell(1'b0);
      for (int k = 0; k < BYTE_BITS; k++)
         send_cell(~data[k]);
      send_cell(~par);
      // keep the line high after a parity error so no false start follows
      send_cell(bad_stop | bad_parity);
      idle_line(gap);
      frames_sent++;
   endtask

   task automatic settle(input int pad);
      idle_line(pad);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the bit period, then read it straight back
   task automatic set_bit_ticks(input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BIT_TICKS_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      cur_bit_ticks = value;
      settings_used++;
   endtask

   task automatic random_item();
      int         choice;
      int         count;
      logic [7:0] rand_byte;
      logic       bad_par;
      logic       bad_stop;
      choice = $urandom_range(19);
      if (choice < 16) begin
         rand_byte = 8'($urandom_range(255));
         bad_par   = ($urandom_range(7) == 0);
         bad_stop  = ($urandom_range(7) == 0);
         send_frame(rand_byte, bad_par, bad_stop,
                    $urandom_range((bad_par || bad_stop) ? 0 : 1, 2 * cur_bit_ticks));
      end else if (choice < 18) begin
         // random line noise, then enough high line to finish any frame it started
         count = $urandom_range(1, 3 * cur_bit_ticks);
         repeat (count) send_sample(1'($urandom_range(1)));
         idle_line(12 * cur_bit_ticks + 4);
      end else begin
         // frame cut short after a few cells
         send_cell(1'b0);
         count = $urandom_range(0, 7);
         repeat (count) send_cell(1'($urandom_range(1)));
         idle_line(12 * cur_bit_ticks + 4);
      end
   endtask

   initial begin
      int phase_start;
      int phase_frames;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= REQ_DATA_W'(1);
      rsp_tready  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      idle_pct      = 0;
      stall_pct     = 0;
      hold_kick     = 1'b0;
      hold_left     = 0;
      cur_bit_ticks = BIT_TICKS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // read back the reset value before the first write
      csr_psel    <= 1'b1;
      csr_paddr   <= BIT_TICKS_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;

      // directed: shortest period, start edge on the very first beat
      set_bit_ticks(16'd2);
      send_frame(8'h00, 1'b0, 1'b0, 2);
      send_frame(8'hFF, 1'b0, 1'b0, 1);
      send_frame(8'h01, 1'b0, 1'b0, 3);
      send_frame(8'h80, 1'b0, 1'b0, 1);
      send_frame(8'h55, 1'b1, 1'b0, 2);
      send_frame(8'hAA, 1'b0, 1'b1, 0);
      // back to back after a stop error: no idle beat between frames
      send_frame(8'h3C, 1'b0, 1'b1, 0);
      send_frame(8'hC3, 1'b1, 1'b1, 2);
      // single low glitch starts a frame of an all-high line
      send_sample(1'b0);
      settle(12 * cur_bit_ticks + 4);

      // odd period
      set_bit_ticks(16'd3);
      send_frame(8'hA5, 1'b0, 1'b0, 1);
      send_frame(8'h5A, 1'b0, 1'b1, 1);
      send_frame(8'h0F, 1'b1, 1'b0, 3);
      send_frame(8'hF0, 1'b0, 1'b0, 2);
      settle(12 * cur_bit_ticks + 4);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               set_bit_ticks(16'd3);
               hold_kick = 1'b1;
            end
            1: begin
               idle_pct  = 88;
               stall_pct = 0;
               set_bit_ticks(16'($urandom_range(2, 4)));
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 88;
               set_bit_ticks(16'd2);
            end
            default: begin
               idle_pct  = 33;
               stall_pct = 33;
               set_bit_ticks(16'($urandom_range(3, 5)));
            end
         endcase
         phase_start  = samples_sent;
         phase_frames = 0;
         while (samples_sent - phase_start < SAMPLE_TARGET || phase_frames < FRAME_TARGET) begin
            random_item();
            phase_frames++;
         end
         settle(12 * cur_bit_ticks + 4);
      end

      // a longer period for a handful of frames
      idle_pct  = 0;
      stall_pct = 50;
      set_bit_ticks(16'd7);
      repeat (3) send_frame(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 5);
      settle(12 * cur_bit_ticks + 4);

      // longest period: register only, line held idle so no frame starts
      set_bit_ticks(16'hFFFF);
      idle_line(40);
      settle(0);

      $display("summary: %0d line samples, %0d frames checked, %0d bit period settings",
               samples_sent, frames_checked, settings_used);
      $display("idle and stall mixes ran, with one long result hold-off");
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### serial_frame_receiver.f
src/frs_pkg.sv
src/frs_csr.sv
src/frs_core.sv
src/serial_frame_receiver.sv
test/frs_frame_checker.sv
test/tb_serial_frame_receiver.sv
